### rtl/upc_pkg.sv
package upc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;

  // Escape phase codes
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  // Codec mode codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [ByteW-1:0] CH_PLUS    = 8'h2B;
  localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
  localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;
  localparam logic [ByteW-1:0] CH_TILDE   = 8'h7E;
  localparam logic [ByteW-1:0] CH_DASH    = 8'h2D;
  localparam logic [ByteW-1:0] CH_UNDER   = 8'h5F;
  localparam logic [ByteW-1:0] CH_DOT     = 8'h2E;
  localparam logic [ByteW-1:0] HEX_ALPHA  = 8'd55;
  localparam logic [ByteW-1:0] HEX_DIGIT  = 8'd48;

  typedef struct packed {
    logic            bad;
    logic [NibW-1:0] val;
  } hex_dec_t;

  function automatic logic [ByteW-1:0] hex_char(input logic [NibW-1:0] v);
    logic [ByteW-1:0] w;
    w = {{(ByteW-NibW){1'b0}}, v};
    return (v > 4'd9) ? w + HEX_ALPHA : w + HEX_DIGIT;
  endfunction

  function automatic hex_dec_t hex_value(input logic [ByteW-1:0] c);
    hex_dec_t r;
    r.bad = 1'b0;
    r.val = '0;
    if (c inside {[8'h41:8'h46]}) begin
      r.val = NibW'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.val = NibW'(c - 8'h57);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.val = NibW'(c - 8'h30);
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  function automatic logic passes(input logic [ByteW-1:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) ||
           c == CH_DASH || c == CH_UNDER || c == CH_DOT || c == CH_TILDE;
  endfunction

endpackage

### rtl/upc_in_if.sv
interface upc_in_if;
  import upc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             message_last;

  modport source (output valid, output in_byte, output message_last, input ready);
  modport sink   (input valid, input in_byte, input message_last, output ready);
endinterface

### rtl/upc_out_if.sv
interface upc_out_if;
  import upc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             run_last;
  logic             message_end;
  logic             bad_escape;

  modport source (output valid, output out_byte, output run_last, output message_end,
                  output bad_escape, input ready);
  modport sink   (input valid, input out_byte, input run_last, input message_end,
                  input bad_escape, output ready);
endinterface

### rtl/url_percent_codec_core.sv
// URL percent codec (form-urlencoded flavor), one byte per input beat.
// Channels: in_i carries in_byte and message_last, out_o carries out_byte,
// run_last, message_end and bad_escape; both use valid/ready, a beat moves
// on a rising edge with valid and ready high. cfg_we_i/cfg_wdata_i set the
// mode (0 encode, 1 decode); write it only while the block is idle. A mode
// write also drops any open escape.
// An accepted byte lands in the item register; its first result is then
// loaded into the result register, from which the receiver takes it.
// Throughput: one byte per cycle when it gives one or no result and the
// receiver does not stall; an encoded byte that needs an escape gives three
// results and holds the item register until the last is loaded into the
// single result register.
// Reset clears the mode to encode, the escape state and both valid flags.
// When the receiver stalls, the result register holds its beat, the item
// register holds a byte with results left; in_i.ready drops till a slot frees.
module url_percent_codec_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  upc_in_if.sink    in_i,
  upc_out_if.source out_o
);
  import upc_pkg::*;

  logic             mode_q;
  logic [1:0]       phase_q, phase_d;
  logic [NibW-1:0]  hi_q, hi_d;
  logic             dbad_q, dbad_d;

  logic             s_valid_q;
  logic [ByteW-1:0] s_byte_q;
  logic             s_last_q;
  logic [1:0]       idx_q;

  logic             o_valid_q;
  logic [ByteW-1:0] o_byte_q, o_byte_d;
  logic             o_run_q, o_mend_q, o_bad_q, o_bad_d;

  logic [1:0]       n_res;
  logic             out_load, at_end, pop;
  hex_dec_t         hv;

  assign hv       = hex_value(s_byte_q);
  assign out_load = !o_valid_q || out_o.ready;
  assign at_end   = (idx_q == n_res - 2'd1);
  assign pop      = s_valid_q && ((n_res == 2'd0) || (out_load && at_end));
  assign in_i.ready = !s_valid_q || pop;

  // Result count, current result and next escape state for the held byte
  always_comb begin
    n_res    = 2'd1;
    o_byte_d = s_byte_q;
    o_bad_d  = 1'b0;
    phase_d  = phase_q;
    hi_d     = hi_q;
    dbad_d   = dbad_q;
    if (mode_q == MODE_ENCODE) begin
      if (passes(s_byte_q)) begin
        o_byte_d = s_byte_q;
      end else if (s_byte_q == CH_SPACE) begin
        o_byte_d = CH_PLUS;
      end else begin
        n_res = 2'd3;
        case (idx_q)
          2'd0:    o_byte_d = CH_PERCENT;
          2'd1:    o_byte_d = hex_char(s_byte_q[7:4]);
          default: o_byte_d = hex_char(s_byte_q[3:0]);
        endcase
      end
    end else begin
      case (phase_q)
        ESC_HIGH: begin
          n_res    = s_last_q ? 2'd1 : 2'd0;
          o_byte_d = {hv.val, {NibW{1'b0}}};
          o_bad_d  = 1'b1;
          phase_d  = ESC_LOW;
          hi_d     = hv.val;
          dbad_d   = dbad_q | hv.bad;
        end
        ESC_LOW: begin
          o_byte_d = {hi_q, hv.val};
          o_bad_d  = dbad_q | hv.bad;
          phase_d  = ESC_NONE;
          hi_d     = '0;
          dbad_d   = 1'b0;
        end
        default: begin
          if (s_byte_q == CH_PERCENT) begin
            n_res    = s_last_q ? 2'd1 : 2'd0;
            o_byte_d = '0;
            o_bad_d  = 1'b1;
            phase_d  = ESC_HIGH;
            hi_d     = '0;
            dbad_d   = 1'b0;
          end else if (s_byte_q == CH_PLUS) begin
            o_byte_d = CH_SPACE;
          end
        end
      endcase
      // Message end drops any open escape
      if (s_last_q) begin
        phase_d = ESC_NONE;
        hi_d    = '0;
        dbad_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ENCODE;
      phase_q <= ESC_NONE;
      hi_q    <= '0;
      dbad_q  <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q  <= cfg_wdata_i;
      phase_q <= ESC_NONE;
      hi_q    <= '0;
      dbad_q  <= 1'b0;
    end else if (pop) begin
      phase_q <= phase_d;
      hi_q    <= hi_d;
      dbad_q  <= dbad_d;
    end
  end

  // Item register and result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      idx_q     <= 2'd0;
    end else begin
      if (in_i.ready) begin
        s_valid_q <= in_i.valid;
      end
      if (pop) begin
        idx_q <= 2'd0;
      end else if (s_valid_q && out_load) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s_byte_q <= in_i.in_byte;
      s_last_q <= in_i.message_last;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (out_load) begin
      o_valid_q <= s_valid_q && (n_res != 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s_valid_q && (n_res != 2'd0)) begin
      o_byte_q <= o_byte_d;
      o_run_q  <= at_end;
      o_mend_q <= at_end && s_last_q;
      o_bad_q  <= o_bad_d;
    end
  end

  assign out_o.valid       = o_valid_q;
  assign out_o.out_byte    = o_byte_q;
  assign out_o.run_last    = o_run_q;
  assign out_o.message_end = o_mend_q;
  assign out_o.bad_escape  = o_bad_q;

endmodule
